>>> rtl/fsd_pkg.sv
// shared types and constants for the floyd-steinberg dither block
// used by the top level, fsd_csr and fsd_core under rtl; depends on nothing
package fsd_pkg;

   // fixed field and register widths
   localparam int PIXEL_W     = 8;
   localparam int WIDTH_REG_W = 12;
   localparam int THR_W       = 8;
   localparam int APB_ADDR_W  = 3;
   localparam int APB_DATA_W  = 32;

   // register select: byte address bit 2 picks the register
   localparam int REG_SEL_BIT = 2;
   localparam logic REG_IMAGE_WIDTH = 1'b0;
   localparam logic REG_THRESHOLD   = 1'b1;

   localparam logic [WIDTH_REG_W-1:0] IMAGE_WIDTH_RESET = WIDTH_REG_W'(640);
   localparam logic [THR_W-1:0]       THRESHOLD_RESET   = THR_W'(128);

   // output levels
   localparam logic [PIXEL_W-1:0] PIX_WHITE = 8'hFF;
   localparam logic [PIXEL_W-1:0] PIX_BLACK = 8'h00;

   // error shares in sixteenths
   localparam logic [2:0] SHARE_RIGHT       = 3'd7;
   localparam logic [2:0] SHARE_BELOW_LEFT  = 3'd3;
   localparam logic [2:0] SHARE_BELOW       = 3'd5;
   localparam logic [2:0] SHARE_BELOW_RIGHT = 3'd1;
   localparam int         SHARE_SHIFT       = 4;

   typedef struct packed {
      logic [WIDTH_REG_W-1:0] image_width;
      logic [THR_W-1:0]       threshold;
   } cfg_type;

endpackage

>>> rtl/floyd_steinberg_dither.sv
// floyd-steinberg dither top level: one 8-bit grey item in, one black/white item out
// one compute stage, then the result register, lie between an accepted item and its rsp_tvalid
// throughput: 1 item per cycle unless rsp_tready stalls; one row store read and one write per cycle
// reset: column, first-row flag, carried errors and valid flags clear at once
// the row store is not cleared; a fill mark makes never-written entries read as zero
module floyd_steinberg_dither #(
   parameter int MAX_WIDTH = 2048,
   parameter int FRAC_BITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fsd_pkg::PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   input  logic                            req_tuser,   // [0] frame_start
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fsd_pkg::PIXEL_W-1:0]     rsp_tdata,   // [7:0] out_pixel
   output logic                            rsp_tlast,   // row_end
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fsd_pkg::APB_ADDR_W-1:0]  csr_paddr,
   input  logic [fsd_pkg::APB_DATA_W-1:0]  csr_pwdata,
   output logic [fsd_pkg::APB_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = 10 + FRAC_BITS;

   fsd_pkg::cfg_type cfg;
   logic             mem_rd_en;
   logic [CW-1:0]    mem_rd_addr;
   logic [EW-1:0]    mem_rd_data;
   logic             mem_wr_en;
   logic [CW-1:0]    mem_wr_addr;
   logic [EW-1:0]    mem_wr_data;

   fsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fsd_row_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (EW)
   ) u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   fsd_core #(
      .MAX_WIDTH (MAX_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

>>> rtl/fsd_csr.sv
// apb-style configuration registers of the dither block
// depends on fsd_pkg
module fsd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fsd_pkg::APB_ADDR_W-1:0]      csr_paddr,
   input  logic [fsd_pkg::APB_DATA_W-1:0]      csr_pwdata,
   output logic [fsd_pkg::APB_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output fsd_pkg::cfg_type                    cfg
);

   logic [fsd_pkg::WIDTH_REG_W-1:0] image_width_ff, image_width_in;
   logic [fsd_pkg::THR_W-1:0]       threshold_ff, threshold_in;
   logic                            wr_go;
   logic                            reg_sel;

   assign csr_pready = 1'b1;
   assign wr_go      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[fsd_pkg::REG_SEL_BIT];

   always_comb begin
      image_width_in = image_width_ff;
      threshold_in   = threshold_ff;
      csr_prdata     = '0;
      unique case (reg_sel)
         fsd_pkg::REG_IMAGE_WIDTH: begin
            csr_prdata = fsd_pkg::APB_DATA_W'(image_width_ff);
            if (wr_go) begin
               image_width_in = csr_pwdata[fsd_pkg::WIDTH_REG_W-1:0];
            end
         end
         fsd_pkg::REG_THRESHOLD: begin
            csr_prdata = fsd_pkg::APB_DATA_W'(threshold_ff);
            if (wr_go) begin
               threshold_in = csr_pwdata[fsd_pkg::THR_W-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= fsd_pkg::IMAGE_WIDTH_RESET;
         threshold_ff   <= fsd_pkg::THRESHOLD_RESET;
      end else begin
         image_width_ff <= image_width_in;
         threshold_ff   <= threshold_in;
      end
   end

   assign cfg.image_width = image_width_ff;
   assign cfg.threshold   = threshold_ff;

endmodule

>>> rtl/fsd_row_store.sv
// one-row error store: single write port, registered read port
// entries past the fill mark have never been written and read as zero
module fsd_row_store #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data
);

   localparam int FW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_hit_ff;
   logic [FW-1:0]     fill_ff, fill_in;

   // writes always extend a prefix, so one mark covers every written entry
   always_comb begin
      fill_in = fill_ff;
      if (wr_en && (FW'(wr_addr) >= fill_ff)) begin
         fill_in = FW'(wr_addr) + FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= FW'(rd_addr) < fill_ff;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

   a_write_prefix: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (FW'(wr_addr) <= fill_ff))
      else $error("row store write leaves a gap above the fill mark");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(fill_ff))
      else $error("fill mark moved without a write");

endmodule

>>> rtl/fsd_core.sv
// column tracking, error arithmetic and result register of the dither block
// depends on fsd_pkg; drives the row store ports of fsd_row_store
module fsd_core #(
   parameter int MAX_WIDTH = 2048,
   parameter int FRAC_BITS = 4
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fsd_pkg::cfg_type                        cfg,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [fsd_pkg::PIXEL_W-1:0]             req_tdata,
   input  logic                                    req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [fsd_pkg::PIXEL_W-1:0]             rsp_tdata,
   output logic                                    rsp_tlast,
   output logic                                    mem_rd_en,
   output logic [$clog2(MAX_WIDTH)-1:0]            mem_rd_addr,
   input  logic [10+FRAC_BITS-1:0]                 mem_rd_data,
   output logic                                    mem_wr_en,
   output logic [$clog2(MAX_WIDTH)-1:0]            mem_wr_addr,
   output logic [10+FRAC_BITS-1:0]                 mem_wr_data
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int EW   = 10 + FRAC_BITS;
   localparam int VW   = EW + 2;
   localparam int PW   = EW + 4;
   localparam int CMPW = (CW + 1 > fsd_pkg::WIDTH_REG_W) ? CW + 1 : fsd_pkg::WIDTH_REG_W;
   localparam logic signed [VW-1:0] ERR_MAX = VW'((1 << (EW - 1)) - 1);
   localparam logic signed [VW-1:0] ERR_MIN = ~ERR_MAX;

   function automatic logic signed [EW-1:0] sat_err(input logic signed [VW-1:0] x);
      logic signed [EW-1:0] r;
      if (x > ERR_MAX) begin
         r = ERR_MAX[EW-1:0];
      end else if (x < ERR_MIN) begin
         r = ERR_MIN[EW-1:0];
      end else begin
         r = x[EW-1:0];
      end
      return r;
   endfunction

   // (err * k) >>> 4, floor rounding
   function automatic logic signed [VW-1:0] share(input logic signed [EW-1:0] err,
                                                  input logic [2:0] k);
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] shifted;
      prod    = PW'(err) * $signed(PW'(k));
      shifted = prod >>> fsd_pkg::SHARE_SHIFT;
      return shifted[VW-1:0];
   endfunction

   // accept side
   logic              acc;
   logic              fs_acc;
   logic [CW-1:0]     c_acc;
   logic [CW-1:0]     wm1;
   logic              last_acc;
   logic              first_acc;
   logic [CW-1:0]     col_ff, col_in;
   logic              first_ff, first_in;

   // compute stage
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_go;
   logic [fsd_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic                        s1_fs_ff;
   logic [CW-1:0]               s1_col_ff;
   logic                        s1_last_ff;
   logic                        s1_first_ff;
   logic                        s1_fwd_ff;
   logic [EW-1:0]               s1_fwd_data_ff;

   logic                        fwd_hit;
   logic [EW-1:0]               fwd_data;

   // error state
   logic signed [EW-1:0] right_ff, right_in;
   logic signed [EW-1:0] pbl_ff, pbl_in;
   logic signed [EW-1:0] pb_ff, pb_in;
   logic signed [EW-1:0] right_cur, pbl_cur, pb_cur, above;
   logic signed [VW-1:0] pix_fx, thr_fx, white_fx, v, diff;
   logic signed [EW-1:0] e;
   logic                 white;
   logic signed [EW-1:0] bl_new, pbl_new, pb_new, right_new;

   // row end write of the current column is registered and goes out in the following cycle
   logic          def_valid_ff, def_valid_in;
   logic [CW-1:0] def_addr_ff;
   logic [EW-1:0] def_data_ff;

   logic          prim_en;
   logic [CW-1:0] prim_addr;
   logic          sec_en;

   // result register
   logic out_valid_ff, out_valid_in;
   logic out_white_ff;
   logic out_last_ff;

   assign acc    = req_tvalid && req_tready;
   assign fs_acc = req_tuser;
   assign c_acc  = fs_acc ? '0 : col_ff;

   always_comb begin
      if (cfg.image_width == '0) begin
         wm1 = '0;
      end else if (CMPW'(cfg.image_width) > CMPW'(MAX_WIDTH)) begin
         wm1 = CW'(MAX_WIDTH - 1);
      end else begin
         wm1 = CW'(cfg.image_width - fsd_pkg::WIDTH_REG_W'(1));
      end
   end

   assign last_acc  = c_acc >= wm1;
   assign first_acc = fs_acc || first_ff;
   assign col_in    = acc ? (last_acc ? '0 : c_acc + CW'(1)) : col_ff;
   assign first_in  = acc ? (first_acc && !last_acc) : first_ff;

   assign s1_go       = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign s1_valid_in = acc || (s1_valid_ff && !s1_go);

   // datapath of the item in the compute stage
   always_comb begin
      right_cur = s1_fs_ff ? '0 : right_ff;
      pbl_cur   = s1_fs_ff ? '0 : pbl_ff;
      pb_cur    = s1_fs_ff ? '0 : pb_ff;
      if (s1_first_ff) begin
         above = '0;
      end else if (s1_fwd_ff) begin
         above = s1_fwd_data_ff;
      end else begin
         above = mem_rd_data;
      end
      pix_fx   = $signed(VW'(s1_pixel_ff)) <<< FRAC_BITS;
      thr_fx   = $signed(VW'(cfg.threshold)) <<< FRAC_BITS;
      white_fx = $signed(VW'(fsd_pkg::PIX_WHITE)) <<< FRAC_BITS;
      v        = pix_fx + VW'(right_cur) + VW'(above);
      white    = v > thr_fx;
      diff     = v - (white ? white_fx : '0);
      e        = sat_err(diff);
      bl_new    = sat_err(VW'(pbl_cur) + share(e, fsd_pkg::SHARE_BELOW_LEFT));
      pbl_new   = sat_err(VW'(pb_cur) + share(e, fsd_pkg::SHARE_BELOW));
      pb_new    = sat_err(share(e, fsd_pkg::SHARE_BELOW_RIGHT));
      right_new = sat_err(share(e, fsd_pkg::SHARE_RIGHT));
   end

   always_comb begin
      right_in = right_ff;
      pbl_in   = pbl_ff;
      pb_in    = pb_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            right_in = '0;
            pbl_in   = '0;
            pb_in    = '0;
         end else begin
            right_in = right_new;
            pbl_in   = pbl_new;
            pb_in    = pb_new;
         end
      end
   end

   assign prim_en      = s1_go && (s1_col_ff != '0);
   assign prim_addr    = s1_col_ff - CW'(1);
   assign sec_en       = s1_go && s1_last_ff;
   assign def_valid_in = sec_en;

   // a column after a row end is column zero, so it never writes alongside
   assign mem_wr_en   = prim_en || def_valid_ff;
   assign mem_wr_addr = prim_en ? prim_addr : def_addr_ff;
   assign mem_wr_data = prim_en ? bl_new : def_data_ff;
   assign mem_rd_en   = acc;
   assign mem_rd_addr = c_acc;

   // bypass for writes that land in the same cycle as the read, and for the deferred row end write
   always_comb begin
      fwd_hit  = 1'b0;
      fwd_data = '0;
      if (prim_en && (prim_addr == c_acc)) begin
         fwd_hit  = 1'b1;
         fwd_data = bl_new;
      end else if (sec_en && (s1_col_ff == c_acc)) begin
         fwd_hit  = 1'b1;
         fwd_data = pbl_new;
      end else if (def_valid_ff && (def_addr_ff == c_acc)) begin
         fwd_hit  = 1'b1;
         fwd_data = def_data_ff;
      end
   end

   assign out_valid_in = s1_go || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         def_valid_ff <= 1'b0;
         right_ff     <= '0;
         pbl_ff       <= '0;
         pb_ff        <= '0;
      end else begin
         col_ff       <= col_in;
         first_ff     <= first_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         def_valid_ff <= def_valid_in;
         right_ff     <= right_in;
         pbl_ff       <= pbl_in;
         pb_ff        <= pb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pixel_ff    <= req_tdata;
         s1_fs_ff       <= fs_acc;
         s1_col_ff      <= c_acc;
         s1_last_ff     <= last_acc;
         s1_first_ff    <= first_acc;
         s1_fwd_ff      <= fwd_hit;
         s1_fwd_data_ff <= fwd_data;
      end
      if (sec_en) begin
         def_addr_ff <= s1_col_ff;
         def_data_ff <= pbl_new;
      end
      if (s1_go) begin
         out_white_ff <= white;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_white_ff ? fsd_pkg::PIX_WHITE : fsd_pkg::PIX_BLACK;
   assign rsp_tlast  = out_last_ff;

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(prim_en && def_valid_ff))
      else $error("row store write port claimed twice");

   a_row_end_wraps: assert property (@(posedge clock) disable iff (reset)
      (acc && last_acc) |=> (col_ff == '0) && !first_ff)
      else $error("column did not wrap after a row end");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_pixel_ff))
      else $error("stalled item in compute stage was lost");

   a_result_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == fsd_pkg::PIX_WHITE || rsp_tdata == fsd_pkg::PIX_BLACK))
      else $error("dithered pixel is neither black nor white");

endmodule

>>> verif/tb_top.sv
// self-checking bench for floyd_steinberg_dither: drives grey items, checks dithered items
// against directed values or an in-bench error-diffusion predictor; depends on rtl/fsd_pkg.sv and the top level
module tb_top;

   localparam int MAX_W          = 2048;
   localparam int FRAC           = 4;
   localparam int ERR_HI         = 8191;
   localparam int ERR_LO         = -8192;
   localparam int TARGET_ITEMS   = 450;
   localparam int CALM_TAIL      = 70;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int N_DIR          = 27;

   typedef enum {ROW_PIXEL, ROW_WIDTH, ROW_THRESH} row_kind_type;

   typedef struct {
      row_kind_type kind;
      int           value;
      bit           fs;
      bit           known;
      int           exp_pix;
      bit           exp_last;
   } stim_row_type;

   typedef struct {
      logic [fsd_pkg::PIXEL_W-1:0] out_pix;
      logic                        row_end;
   } dith_out_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [fsd_pkg::PIXEL_W-1:0]    req_tdata = '0;
   logic                           req_tuser = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [fsd_pkg::PIXEL_W-1:0]    rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [fsd_pkg::APB_ADDR_W-1:0] csr_paddr = '0;
   logic [fsd_pkg::APB_DATA_W-1:0] csr_pwdata = '0;
   logic [fsd_pkg::APB_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // typed expectation travelling with the current item
   bit                             req_known = 1'b0;
   logic [fsd_pkg::PIXEL_W-1:0]    req_exp_pix = '0;
   bit                             req_exp_last = 1'b0;

   // predictor state
   int                             row_err_mem [MAX_W];
   int                             carry_right = 0;
   int                             gather_left = 0;
   int                             gather_here = 0;
   int                             col = 0;
   bit                             in_first_row = 1'b1;
   logic [fsd_pkg::WIDTH_REG_W-1:0] cfg_width = fsd_pkg::IMAGE_WIDTH_RESET;
   logic [fsd_pkg::THR_W-1:0]       cfg_thr   = fsd_pkg::THRESHOLD_RESET;

   dith_out_type          dither_due_q [$];
   int                    fail_count = 0;
   int                    items_in = 0;
   int                    results_seen = 0;
   int                    idle_cycles = 0;
   int                    stall_left = 0;
   bit                    calm = 1'b0;

   stim_row_type dir_tab [N_DIR] = '{
      '{ROW_PIXEL,    0, 1'b1, 1'b1,   0, 1'b0},
      '{ROW_PIXEL,  255, 1'b1, 1'b1, 255, 1'b0},
      '{ROW_PIXEL,  128, 1'b1, 1'b1,   0, 1'b0},   // equal to threshold stays black
      '{ROW_PIXEL,  129, 1'b1, 1'b1, 255, 1'b0},
      '{ROW_WIDTH,    1, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  200, 1'b0, 1'b0,   0, 1'b0},   // column already past new width
      '{ROW_PIXEL,    0, 1'b1, 1'b1,   0, 1'b1},
      '{ROW_PIXEL,  255, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_WIDTH,    0, 1'b0, 1'b0,   0, 1'b0},   // zero width acts as one
      '{ROW_PIXEL,  255, 1'b1, 1'b1, 255, 1'b1},
      '{ROW_PIXEL,   90, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_THRESH,   0, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,    0, 1'b1, 1'b1,   0, 1'b1},
      '{ROW_PIXEL,    1, 1'b1, 1'b1, 255, 1'b1},
      '{ROW_THRESH, 255, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  255, 1'b1, 1'b1,   0, 1'b1},
      '{ROW_WIDTH, 4095, 1'b0, 1'b0,   0, 1'b0},   // clamps to the store size
      '{ROW_PIXEL,  255, 1'b1, 1'b1,   0, 1'b0},
      '{ROW_PIXEL,   17, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  240, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  128, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_WIDTH,    2, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,   60, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_THRESH, 128, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  200, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,   10, 1'b0, 1'b0,   0, 1'b0},
      '{ROW_PIXEL,  255, 1'b0, 1'b0,   0, 1'b0}
   };

   floyd_steinberg_dither i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int clip_err(int x);
      if (x > ERR_HI) return ERR_HI;
      if (x < ERR_LO) return ERR_LO;
      return x;
   endfunction

   // arithmetic shift on int rounds toward minus infinity
   function automatic int share_of(int e, int k);
      return (e * k) >>> fsd_pkg::SHARE_SHIFT;
   endfunction

   function automatic dith_out_type dither_pixel(logic [fsd_pkg::PIXEL_W-1:0] pix, logic fs);
      int           w;
      int           c;
      int           above;
      int           v;
      int           e;
      int           level;
      bit           white;
      bit           last;
      dith_out_type r;
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (fs) begin
         col = 0;
         carry_right = 0;
         gather_left = 0;
         gather_here = 0;
         in_first_row = 1'b1;
      end
      c = col;
      if (c >= MAX_W) c = MAX_W - 1;
      last = (c >= w - 1);
      above = in_first_row ? 0 : row_err_mem[c];
      v = (int'(pix) << FRAC) + carry_right + above;
      white = v > (int'(cfg_thr) << FRAC);
      level = white ? int'(fsd_pkg::PIX_WHITE) : int'(fsd_pkg::PIX_BLACK);
      e = clip_err(v - (level << FRAC));
      if (c >= 1) begin
         row_err_mem[c-1] = clip_err(gather_left + share_of(e, int'(fsd_pkg::SHARE_BELOW_LEFT)));
      end
      gather_left = clip_err(gather_here + share_of(e, int'(fsd_pkg::SHARE_BELOW)));
      gather_here = clip_err(share_of(e, int'(fsd_pkg::SHARE_BELOW_RIGHT)));
      carry_right = clip_err(share_of(e, int'(fsd_pkg::SHARE_RIGHT)));
      if (last) begin
         row_err_mem[c] = gather_left;
         gather_left = 0;
         gather_here = 0;
         carry_right = 0;
         col = 0;
         in_first_row = 1'b0;
      end else begin
         col = c + 1;
      end
      r.out_pix = white ? fsd_pkg::PIX_WHITE : fsd_pkg::PIX_BLACK;
      r.row_end = last;
      return r;
   endfunction

   // everything is sampled here, at the rising edge
   always @(posedge clock) begin : monitor
      dith_out_type due;
      bit           busy;
      busy = 1'b0;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            busy = 1'b1;
            if (csr_paddr[fsd_pkg::REG_SEL_BIT] == fsd_pkg::REG_IMAGE_WIDTH) begin
               cfg_width = csr_pwdata[fsd_pkg::WIDTH_REG_W-1:0];
            end else begin
               cfg_thr = csr_pwdata[fsd_pkg::THR_W-1:0];
            end
         end
         if (csr_psel && csr_penable && csr_pready) busy = 1'b1;
         if (req_tvalid && req_tready) begin
            busy = 1'b1;
            due = dither_pixel(req_tdata, req_tuser);
            if (req_known) begin
               due.out_pix = req_exp_pix;
               due.row_end = req_exp_last;
            end
            dither_due_q.push_back(due);
            items_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            busy = 1'b1;
            results_seen++;
            if (dither_due_q.size() == 0) begin
               $error("item with nothing owed: out_pixel %0d row_end %0d", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               due = dither_due_q.pop_front();
               if (rsp_tdata !== due.out_pix) begin
                  $error("out_pixel: expected %0d, got %0d", due.out_pix, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== due.row_end) begin
                  $error("row_end: expected %0d, got %0d", due.row_end, rsp_tlast);
                  fail_count++;
               end
            end
         end
         idle_cycles = busy ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 4);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance with tvalid still high
   task automatic push_pixel(input logic [fsd_pkg::PIXEL_W-1:0] pix, input logic fs,
                             input bit known, input int xp, input bit xl);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= pix;
      req_tuser    <= fs;
      req_known    <= known;
      req_exp_pix  <= fsd_pkg::PIXEL_W'(xp);
      req_exp_last <= xl;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (dither_due_q.size() != 0) @(negedge clock);
   endtask

   // write then read back one register; only used with the block idle
   task automatic csr_write(input logic sel, input int value);
      logic [fsd_pkg::APB_ADDR_W-1:0] addr;
      int                             mask;
      addr = '0;
      addr[fsd_pkg::REG_SEL_BIT] = sel;
      mask = (sel == fsd_pkg::REG_IMAGE_WIDTH) ? (1 << fsd_pkg::WIDTH_REG_W) - 1
                                               : (1 << fsd_pkg::THR_W) - 1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= fsd_pkg::APB_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== fsd_pkg::APB_DATA_W'(value & mask)) begin
         $error("csr readback: expected %0h, got %0h", value & mask, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // bias towards the extremes and the band around the threshold
   function automatic logic [fsd_pkg::PIXEL_W-1:0] pick_pixel();
      int r;
      int p;
      r = $urandom_range(0, 7);
      case (r)
         0: p = 0;
         1: p = 255;
         2, 3: begin
            p = int'(cfg_thr) + $urandom_range(0, 4) - 2;
            if (p < 0) p = 0;
            if (p > 255) p = 255;
         end
         default: p = $urandom_range(0, 255);
      endcase
      return fsd_pkg::PIXEL_W'(p);
   endfunction

   initial begin : stimulus
      int  idx;
      int  n;
      int  w;
      int  r;
      int  frames;
      int  rows;
      int  small_items;
      bit  fs;
      for (idx = 0; idx < MAX_W; idx++) row_err_mem[idx] = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (idx = 0; idx < N_DIR; idx++) begin
         case (dir_tab[idx].kind)
            ROW_WIDTH: begin
               drain();
               csr_write(fsd_pkg::REG_IMAGE_WIDTH, dir_tab[idx].value);
            end
            ROW_THRESH: begin
               drain();
               csr_write(fsd_pkg::REG_THRESHOLD, dir_tab[idx].value);
            end
            default: push_pixel(fsd_pkg::PIXEL_W'(dir_tab[idx].value), dir_tab[idx].fs,
                                dir_tab[idx].known, dir_tab[idx].exp_pix,
                                dir_tab[idx].exp_last);
         endcase
      end

      small_items = 0;
      while (small_items < TARGET_ITEMS) begin
         drain();
         r = $urandom_range(0, 3);
         if (r != 1) begin
            n = $urandom_range(0, 19);
            if (n <= 12) w = $urandom_range(1, 8);
            else if (n <= 16) w = $urandom_range(9, 24);
            else if (n == 17) w = 0;
            else if (n == 18) w = $urandom_range(25, 64);
            else w = $urandom_range(65, 4095);
            csr_write(fsd_pkg::REG_IMAGE_WIDTH, w);
         end
         if (r != 0) begin
            n = $urandom_range(0, 9);
            csr_write(fsd_pkg::REG_THRESHOLD,
                      n == 0 ? 0 : n == 1 ? 255 : $urandom_range(0, 255));
         end
         w = cfg_width;
         if (w == 0) w = 1;
         if (w > 64) begin
            // part of a wide row only; the next batch cuts it short with a frame start or a narrower width
            n = $urandom_range(5, 30);
            for (idx = 0; idx < n && small_items < TARGET_ITEMS; idx++) begin
               push_pixel(pick_pixel(), idx == 0, 1'b0, 0, 1'b0);
               small_items++;
               calm = (small_items >= TARGET_ITEMS - CALM_TAIL);
            end
         end else begin
            frames = $urandom_range(1, 2);
            repeat (frames) begin
               rows = $urandom_range(1, 4);
               fs = ($urandom_range(0, 5) != 0);
               for (idx = 0; idx < rows * w && small_items < TARGET_ITEMS; idx++) begin
                  push_pixel(pick_pixel(), fs || ($urandom_range(0, 39) == 0), 1'b0, 0, 1'b0);
                  fs = 1'b0;
                  small_items++;
                  calm = (small_items >= TARGET_ITEMS - CALM_TAIL);
               end
            end
         end
      end

      drain();
      repeat (4) @(negedge clock);
      $display("covered %0d items and %0d checked results: widths 0 to 4095 with clamping,",
               items_in, results_seen);
      $display("thresholds 0 to 255, multi-row frames, stray frame starts and rows cut short");
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/fsd_pkg.sv
rtl/fsd_csr.sv
rtl/fsd_row_store.sv
rtl/fsd_core.sv
rtl/floyd_steinberg_dither.sv
verif/tb_top.sv
